// ===== src/smf_pkg.sv =====
// shared types and constants for the sorted mode finder
package smf_pkg;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [COUNT_W-1:0]       count_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;  // place the broadcast value in sorted position
    logic shift;   // move every entry one cell toward the head
  } cell_ctrl_t;

endpackage

// ===== src/sorted_mode_finder_top.sv =====
// top level of the sorted mode finder: cell chain, run scan and result register
//
// usage: values stream in on the input channel (sample_value, last_item),
// one transfer per cycle while collecting. each value drops into its sorted
// place in a chain of STORE_DEPTH cells in the cycle it is taken. values
// beyond the chain depth are dropped and flagged in overflow_flag.
// after the transfer marked last_item, input ready falls and the chain
// shifts its contents into the run scanner, one entry per cycle, toward
// the head cell. once every stored value has passed through the head
// cell, a closing compare of the final run gives the result.
// the result (mode_value, mode_found, mode_count, overflow_flag) sits in an
// output register; a new set may be collected while it waits. if the
// receiver still stalls when the next set's scan completes, the scan holds
// its result until the register frees.
// mode_count wraps modulo 32 for depths above 31.
// reset (rst, synchronous) empties the chain and clears the result valid flag.
module sorted_mode_finder_top #(
  parameter int STORE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  smf_pkg::data_t       sample_value,
  input  logic                 last_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output smf_pkg::data_t       mode_value,
  output logic                 mode_found,
  output smf_pkg::count_t      mode_count,
  output logic                 overflow_flag
);
  import smf_pkg::*;

  localparam int CW    = $clog2(STORE_DEPTH + 1);
  localparam int LEN_W = (CW > COUNT_W) ? CW : COUNT_W;

  localparam logic ST_COLLECT = 1'b0;
  localparam logic ST_SCAN    = 1'b1;

  logic state;
  logic overflow_seen;

  data_t value_arr [STORE_DEPTH];
  logic  [STORE_DEPTH-1:0] valid_vec;
  logic  [STORE_DEPTH-1:0] open_vec;

  cell_ctrl_t ctrl;
  logic       in_xfer;
  logic       chain_full;
  logic       scan_step;
  logic       scan_done;
  logic       out_free;
  logic       load;

  data_t            best_value;
  logic [LEN_W-1:0] best_len;
  logic             found;

  assign in_ready   = (state == ST_COLLECT);
  assign in_xfer    = in_valid && in_ready;
  assign chain_full = valid_vec[STORE_DEPTH-1];

  // head cell feeds the scanner while the chain drains
  assign scan_step  = (state == ST_SCAN) && valid_vec[0];
  assign scan_done  = (state == ST_SCAN) && !valid_vec[0];
  assign out_free   = !out_valid || out_ready;
  assign load       = scan_done && out_free;

  assign ctrl.insert = in_xfer && !chain_full;
  assign ctrl.shift  = scan_step;

  // sorted chain: each cell looks at its left and right neighbor only
  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    logic  l_open;
    data_t l_value;
    logic  l_valid;
    data_t r_value;
    logic  r_valid;

    if (i == 0) begin : g_head
      assign l_open  = 1'b0;
      assign l_value = sample_value;
      assign l_valid = 1'b0;
    end else begin : g_body
      assign l_open  = open_vec[i-1];
      assign l_value = value_arr[i-1];
      assign l_valid = valid_vec[i-1];
    end

    if (i == STORE_DEPTH - 1) begin : g_tail
      assign r_value = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_value = value_arr[i+1];
      assign r_valid = valid_vec[i+1];
    end

    smf_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .in_value    (sample_value),
      .left_open   (l_open),
      .left_value  (l_value),
      .left_valid  (l_valid),
      .right_value (r_value),
      .right_valid (r_valid),
      .value       (value_arr[i]),
      .valid       (valid_vec[i]),
      .open        (open_vec[i])
    );
  end

  smf_scan #(
    .LEN_W (LEN_W)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .start      (in_xfer && last_item),
    .step       (scan_step),
    .head_value (value_arr[0]),
    .best_value (best_value),
    .best_len   (best_len),
    .found      (found)
  );

  // collect / drain sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_COLLECT;
      overflow_seen <= 1'b0;
    end else begin
      unique case (state)
        ST_COLLECT: begin
          if (in_xfer) begin
            if (chain_full) begin
              overflow_seen <= 1'b1;
            end
            if (last_item) begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (load) begin
            state         <= ST_COLLECT;
            overflow_seen <= 1'b0;
          end
        end
        default: begin
          state <= ST_COLLECT;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mode_value    <= found ? best_value : '0;
      mode_found    <= found;
      mode_count    <= found ? best_len[COUNT_W-1:0] : '0;
      overflow_flag <= overflow_seen;
    end
  end

`ifndef SYNTH
  // stored entries always sit at the head end of the chain
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec + STORE_DEPTH'(1)) & valid_vec) == '0)
    else $error("chain valid bits not contiguous from head");

  // the chain is empty once a result has been taken from the scan
  a_drained: assert property (@(posedge clk) disable iff (rst)
    load |=> !valid_vec[0])
    else $error("chain not drained after result load");

  // no input is taken while the chain drains
  a_no_insert_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !ctrl.insert)
    else $error("insert during scan");

  // a reported mode repeats at least twice
  a_mode_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && mode_found && (STORE_DEPTH < 32)) |-> (mode_count >= COUNT_W'(2)))
    else $error("mode reported with count below two");

  // no mode means zero value and count
  a_no_mode_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !mode_found) |-> (mode_value == '0 && mode_count == '0))
    else $error("nonzero fields without a mode");
`endif

endmodule

// ===== src/smf_cell.sv =====
// one cell of the sorted chain: holds a value and its valid bit
module smf_cell (
  input  logic               clk,
  input  logic               rst,
  input  smf_pkg::cell_ctrl_t ctrl,
  input  smf_pkg::data_t     in_value,
  input  logic               left_open,
  input  smf_pkg::data_t     left_value,
  input  logic               left_valid,
  input  smf_pkg::data_t     right_value,
  input  logic               right_valid,
  output smf_pkg::data_t     value,
  output logic               valid,
  output logic               open
);
  import smf_pkg::*;

  // open: new value belongs here or to the left of this entry
  assign open = !valid || (value > in_value);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= right_value;
    end else if (ctrl.insert) begin
      if (left_open) begin
        value <= left_value;
      end else if (open) begin
        value <= in_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= right_valid;
    end else if (ctrl.insert) begin
      if (left_open) begin
        valid <= left_valid;
      end else if (open) begin
        valid <= 1'b1;
      end
    end
  end

endmodule

// ===== src/smf_scan.sv =====
// run-length scan over the sorted stream, tracks the longest run
module smf_scan #(
  parameter int LEN_W = 5
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           step,
  input  smf_pkg::data_t head_value,
  output smf_pkg::data_t best_value,
  output logic [LEN_W-1:0] best_len,
  output logic           found
);
  import smf_pkg::*;

  data_t            run_val;
  logic [LEN_W-1:0] run_len;
  data_t            best_val_r;
  logic [LEN_W-1:0] best_len_r;
  logic             found_r;
  logic             run_better;

  assign run_better = run_len > best_len_r;

  always_ff @(posedge clk) begin
    if (rst || start) begin
      run_len    <= '0;
      best_len_r <= LEN_W'(1);
      found_r    <= 1'b0;
    end else if (step) begin
      if (run_len != '0 && head_value == run_val) begin
        run_len <= run_len + LEN_W'(1);
      end else begin
        if (run_better) begin
          best_len_r <= run_len;
          found_r    <= 1'b1;
        end
        run_len <= LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (!(run_len != '0 && head_value == run_val)) begin
        if (run_better) begin
          best_val_r <= run_val;
        end
        run_val <= head_value;
      end
    end
  end

  // closing compare of the final run
  assign found      = found_r || run_better;
  assign best_value = run_better ? run_val : best_val_r;
  assign best_len   = run_better ? run_len : best_len_r;

endmodule
